// ===== sv/cpl3d_pkg.sv =====
// Shared widths, codes and types for the closest-points-between-two-lines block.
package cpl3d_pkg;

	// Coordinate format and derived datapath widths.
	localparam int CW   = 32;
	localparam int FB   = 16;
	localparam int DW   = CW + 1;
	localparam int DOTW = 2 * DW + 2;
	localparam int WW   = 2 * DOTW;
	localparam int WN   = WW + DW + 1;

	// Wide multiplier geometry.
	localparam int LIMB    = 34;
	localparam int MUL_AW  = WW;
	localparam int MUL_BW  = DOTW;
	localparam int MUL_NA  = (MUL_AW + LIMB - 1) / LIMB;
	localparam int MUL_NB  = (MUL_BW + LIMB - 1) / LIMB;
	localparam int MUL_PW  = MUL_AW + MUL_BW;
	localparam int MUL_LAT = 5;

	// Rounding divider geometry.
	localparam int QB      = CW + 2;
	localparam int QW      = QB + 2;
	localparam int DIV_LAT = QB + 2;

	// Configuration registers.
	localparam int ZTW = 16;
	localparam int MLW = 31;
	localparam int PAW = 4;
	localparam logic [1:0] REG_ZERO_THRESHOLD    = 2'd0;
	localparam logic [1:0] REG_MIN_RESULT_LENGTH = 2'd1;
	localparam logic [1:0] REG_LENGTH_CHECK_OFF  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK,
		ST_PARALLEL,
		ST_NO_SOLUTION,
		ST_TOO_SHORT
	} status_t;

	typedef struct packed {
		logic [ZTW-1:0] zero_threshold;
		logic [MLW-1:0] min_result_length;
		logic           length_check_off;
	} cfg_t;

endpackage

// ===== sv/cpl3d_mul.sv =====
// Pipelined wide signed multiplier built from limb partial products.
module cpl3d_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [cpl3d_pkg::MUL_AW-1:0]   a,
	input  logic signed [cpl3d_pkg::MUL_BW-1:0]   b,
	output logic signed [cpl3d_pkg::MUL_PW-1:0]   p
);
	localparam int L  = cpl3d_pkg::LIMB;
	localparam int NA = cpl3d_pkg::MUL_NA;
	localparam int NB = cpl3d_pkg::MUL_NB;
	localparam int AW = cpl3d_pkg::MUL_AW;
	localparam int BW = cpl3d_pkg::MUL_BW;
	localparam int PW = cpl3d_pkg::MUL_PW;

	logic [AW-1:0]   abs_a;
	logic [BW-1:0]   abs_b;
	logic            neg_s1, neg_s2, neg_s3, neg_s4;
	logic [NA*L-1:0] ma_s1;
	logic [NB*L-1:0] mb_s1;
	logic [2*L-1:0]  pp_s2 [NA][NB];
	logic [PW-1:0]   row_s3 [NB];
	logic [PW-1:0]   row_sum [NB];
	logic [PW-1:0]   sum_s4;
	logic [PW-1:0]   total;

	always_comb begin
		abs_a = a[AW-1] ? AW'(-a) : AW'(a);
		abs_b = b[BW-1] ? BW'(-b) : BW'(b);
		for (int j = 0; j < NB; j++) begin
			row_sum[j] = '0;
			for (int i = 0; i < NA; i++) begin
				row_sum[j] = row_sum[j] + (PW'(pp_s2[i][j]) << (i * L));
			end
		end
		total = '0;
		for (int j = 0; j < NB; j++) begin
			total = total + (row_s3[j] << (j * L));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[AW-1] ^ b[BW-1];
			ma_s1  <= (NA*L)'(abs_a);
			mb_s1  <= (NB*L)'(abs_b);
			neg_s2 <= neg_s1;
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= ma_s1[i*L +: L] * mb_s1[j*L +: L];
				end
			end
			neg_s3 <= neg_s2;
			row_s3 <= row_sum;
			neg_s4 <= neg_s3;
			sum_s4 <= total;
			p      <= neg_s4 ? -$signed(sum_s4) : $signed(sum_s4);
		end
	end

endmodule

// ===== sv/cpl3d_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded and clamped.
module cpl3d_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [cpl3d_pkg::WN-1:0]   n,
	input  logic        [cpl3d_pkg::WW-1:0]   d,
	output logic signed [cpl3d_pkg::QW-1:0]   q
);
	localparam int QB = cpl3d_pkg::QB;
	localparam int QW = cpl3d_pkg::QW;
	localparam int RW = cpl3d_pkg::WN;
	localparam int WW = cpl3d_pkg::WW;

	logic [RW-1:0] rem_s [0:QB];
	logic [WW-1:0] dv_s  [0:QB];
	logic [QB-1:0] qt_s  [0:QB];
	logic [QB:0]   neg_s;
	logic [QB:0]   ovf_s;
	logic [RW-1:0] dsh   [1:QB];
	logic [QB:1]   ge;
	logic [RW-1:0] mag;
	logic          rnd;
	logic [QB:0]   magq;

	always_comb begin
		mag = n[RW-1] ? RW'(-n) : RW'(n);
		for (int k = 1; k <= QB; k++) begin
			dsh[k] = RW'(dv_s[k-1]) << (QB - k);
			ge[k]  = rem_s[k-1] >= dsh[k];
		end
		rnd  = (rem_s[QB] << 1) >= RW'(dv_s[QB]);
		magq = ovf_s[QB] ? ((QB+1)'(1) << QB) : ((QB+1)'(qt_s[QB]) + (QB+1)'(rnd));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// A quotient that cannot fit is clamped far outside the coordinate range.
			rem_s[0] <= mag;
			dv_s[0]  <= d;
			qt_s[0]  <= '0;
			neg_s[0] <= n[RW-1];
			ovf_s[0] <= mag >= (RW'(d) << QB);
			for (int k = 1; k <= QB; k++) begin
				rem_s[k] <= ge[k] ? (rem_s[k-1] - dsh[k]) : rem_s[k-1];
				qt_s[k]  <= qt_s[k-1] | (ge[k] ? (QB'(1) << (QB - k)) : QB'(0));
				dv_s[k]  <= dv_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
			q <= neg_s[QB] ? -$signed(QW'(magq)) : $signed(QW'(magq));
		end
	end

endmodule

// ===== sv/cpl3d_cfg.sv =====
// APB-style configuration register file.
module cpl3d_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpl3d_pkg::PAW-1:0]     paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output cpl3d_pkg::cfg_t               cfg
);
	cpl3d_pkg::cfg_t cfg_q;
	logic [1:0]      idx;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_threshold    <= cpl3d_pkg::ZTW'(1);
			cfg_q.min_result_length <= cpl3d_pkg::MLW'(1);
			cfg_q.length_check_off  <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				cpl3d_pkg::REG_ZERO_THRESHOLD: begin
					cfg_q.zero_threshold <= pwdata[cpl3d_pkg::ZTW-1:0];
				end
				cpl3d_pkg::REG_MIN_RESULT_LENGTH: begin
					cfg_q.min_result_length <= pwdata[cpl3d_pkg::MLW-1:0];
				end
				cpl3d_pkg::REG_LENGTH_CHECK_OFF: begin
					cfg_q.length_check_off <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			cpl3d_pkg::REG_ZERO_THRESHOLD:    prdata = 32'(cfg_q.zero_threshold);
			cpl3d_pkg::REG_MIN_RESULT_LENGTH: prdata = 32'(cfg_q.min_result_length);
			cpl3d_pkg::REG_LENGTH_CHECK_OFF:  prdata = 32'(cfg_q.length_check_off);
			default:                          prdata = '0;
		endcase
	end

endmodule

// ===== sv/closest_points_two_lines_3d_top.sv =====
// Top level of the closest-points-between-two-3D-lines pipeline.
//
// The input channel (in_valid/in_ready) takes one word: two segments, each by
// its start and end point, in signed Q16.16. The output channel
// (out_valid/out_ready) returns one word per input word: a status code and the
// closest point on each of the two infinite lines, saturated to Q16.16.
// Points are zero whenever the status is not ok.
// The datapath is a 55-stage pipeline: difference vectors, dot products, a
// wide multiplier pass for the denominator and numerators, a second wide
// multiplier pass for the scaled numerators and the parallel test, six
// rounding dividers that resolve one quotient bit per stage, saturation and
// the result length check. While the output is not stalled, one word is
// taken in every cycle: throughput is one word per clock, set by the
// one-bit-per-stage dividers being fully pipelined.
// When the receiver holds out_ready low with a word waiting, the whole
// pipeline freezes and in_ready drops in the same cycle; nothing is lost.
// Reset clears every valid bit and loads the register defaults; no clearing
// pass is needed. Configuration must be written through the APB-style port
// only while the pipeline is empty; the block itself does not enforce this.
module closest_points_two_lines_3d_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [cpl3d_pkg::PAW-1:0]             paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [cpl3d_pkg::CW-1:0]       first_start_x,
	input  logic signed [cpl3d_pkg::CW-1:0]       first_start_y,
	input  logic signed [cpl3d_pkg::CW-1:0]       first_start_z,
	input  logic signed [cpl3d_pkg::CW-1:0]       first_end_x,
	input  logic signed [cpl3d_pkg::CW-1:0]       first_end_y,
	input  logic signed [cpl3d_pkg::CW-1:0]       first_end_z,
	input  logic signed [cpl3d_pkg::CW-1:0]       second_start_x,
	input  logic signed [cpl3d_pkg::CW-1:0]       second_start_y,
	input  logic signed [cpl3d_pkg::CW-1:0]       second_start_z,
	input  logic signed [cpl3d_pkg::CW-1:0]       second_end_x,
	input  logic signed [cpl3d_pkg::CW-1:0]       second_end_y,
	input  logic signed [cpl3d_pkg::CW-1:0]       second_end_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            status,
	output logic signed [cpl3d_pkg::CW-1:0]       near_first_x,
	output logic signed [cpl3d_pkg::CW-1:0]       near_first_y,
	output logic signed [cpl3d_pkg::CW-1:0]       near_first_z,
	output logic signed [cpl3d_pkg::CW-1:0]       near_second_x,
	output logic signed [cpl3d_pkg::CW-1:0]       near_second_y,
	output logic signed [cpl3d_pkg::CW-1:0]       near_second_z
);
	localparam int CW   = cpl3d_pkg::CW;
	localparam int FB   = cpl3d_pkg::FB;
	localparam int DW   = cpl3d_pkg::DW;
	localparam int DOTW = cpl3d_pkg::DOTW;
	localparam int WW   = cpl3d_pkg::WW;
	localparam int WN   = cpl3d_pkg::WN;
	localparam int PW   = cpl3d_pkg::MUL_PW;
	localparam int QW   = cpl3d_pkg::QW;
	localparam int SW   = QW + 1;
	localparam int GW   = FB + 1;
	localparam int MLW  = cpl3d_pkg::MLW;

	// Stage numbers: a value registered at stage k has passed k registers since acceptance.
	localparam int S_COMB = 4 + cpl3d_pkg::MUL_LAT + 1;
	localparam int S_M2   = S_COMB + cpl3d_pkg::MUL_LAT;
	localparam int S_DV   = S_M2 + cpl3d_pkg::DIV_LAT;
	localparam int S_SAT  = S_DV + 1;
	localparam int S_OUT  = S_SAT + 3;

	// Dot product slots.
	localparam int DI_CB = 0;
	localparam int DI_BA = 1;
	localparam int DI_CA = 2;
	localparam int DI_BB = 3;
	localparam int DI_AA = 4;

	cpl3d_pkg::cfg_t cfg;

	logic                en;
	logic [S_OUT:1]      vld_s;

	logic signed [CW-1:0]     pin_s1 [12];
	logic signed [DW-1:0]     ad_s [2:S_COMB][3];
	logic signed [DW-1:0]     bd_s [2:S_COMB][3];
	logic signed [DW-1:0]     c_s2 [3];
	logic signed [CW-1:0]     fs_s [2:S_DV][3];
	logic signed [CW-1:0]     ss_s [2:S_DV][3];
	logic signed [2*DW-1:0]   pr_s3 [15];
	logic signed [DOTW-1:0]   dot_s4 [5];

	logic signed [cpl3d_pkg::MUL_AW-1:0] m1_a [6];
	logic signed [cpl3d_pkg::MUL_BW-1:0] m1_b [6];
	logic signed [PW-1:0]                m1_p [6];

	logic signed [WW-1:0] full_s10, numa_s10, numb_s10;
	logic signed [WW-1:0] den_s [S_COMB:S_M2];
	logic signed [WW-1:0] ba2_s [S_COMB:S_M2];

	logic signed [cpl3d_pkg::MUL_AW-1:0] m2_a [7];
	logic signed [cpl3d_pkg::MUL_BW-1:0] m2_b [7];
	logic signed [PW-1:0]                m2_p [7];
	logic signed [QW-1:0]                dq [6];

	logic [S_OUT-1:S_M2+1] par_s;
	logic [S_OUT-1:S_M2+1] nos_s;

	logic signed [CW-1:0]   res_s [S_SAT:S_OUT-1][6];
	logic signed [DW-1:0]   dif_s53 [3];
	logic [2*DW-1:0]        sq_s54 [3];

	cpl3d_pkg::status_t     stat_s55;
	logic signed [CW-1:0]   pt_s55 [6];

	// Values derived from configuration, refreshed every cycle.
	logic [GW-1:0]          g;
	logic [2*GW-1:0]        g2_q;
	logic signed [WW-1:0]   thr_q;
	logic [2*MLW-1:0]       lim_q;
	logic                   par_all_q;

	// Combinational results feeding registers.
	logic signed [PW-1:0]   lhs;
	logic                   par_c, nos_c;
	logic signed [SW-1:0]   sat_sum [6];
	logic signed [CW-1:0]   sat_val [6];
	logic [DOTW-1:0]        sq_sum;
	logic                   short_c;
	cpl3d_pkg::status_t     stat_c;

	cpl3d_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The pipeline moves whenever the output register is empty or being taken.
	assign en        = !vld_s[S_OUT] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[S_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[S_OUT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		g2_q      <= g * g;
		thr_q     <= WW'(cfg.zero_threshold) << (3 * FB);
		lim_q     <= cfg.min_result_length * cfg.min_result_length;
		par_all_q <= (GW+1)'(cfg.zero_threshold) > ((GW+1)'(1) << FB);
	end

	assign g = (GW'(1) << FB) - GW'(cfg.zero_threshold);

	// First wide multiplier pass: denominator terms and numerator terms.
	always_comb begin
		m1_a[0] = cpl3d_pkg::MUL_AW'(dot_s4[DI_AA]); m1_b[0] = dot_s4[DI_BB];
		m1_a[1] = cpl3d_pkg::MUL_AW'(dot_s4[DI_BA]); m1_b[1] = dot_s4[DI_BA];
		m1_a[2] = cpl3d_pkg::MUL_AW'(dot_s4[DI_CB]); m1_b[2] = dot_s4[DI_BA];
		m1_a[3] = cpl3d_pkg::MUL_AW'(dot_s4[DI_CA]); m1_b[3] = dot_s4[DI_BB];
		m1_a[4] = cpl3d_pkg::MUL_AW'(dot_s4[DI_CB]); m1_b[4] = dot_s4[DI_AA];
		m1_a[5] = cpl3d_pkg::MUL_AW'(dot_s4[DI_CA]); m1_b[5] = dot_s4[DI_BA];
	end

	// Second pass: scaled numerators per axis, plus the parallel-test product.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m2_a[k]     = numa_s10;
			m2_b[k]     = cpl3d_pkg::MUL_BW'(ad_s[S_COMB][k]);
			m2_a[3 + k] = numb_s10;
			m2_b[3 + k] = cpl3d_pkg::MUL_BW'(bd_s[S_COMB][k]);
		end
		m2_a[6] = full_s10;
		m2_b[6] = cpl3d_pkg::MUL_BW'(g2_q);
	end

	for (genvar i = 0; i < 6; i++) begin : g_m1
		cpl3d_mul u_mul (.clk(clk), .en(en), .a(m1_a[i]), .b(m1_b[i]), .p(m1_p[i]));
	end

	for (genvar i = 0; i < 7; i++) begin : g_m2
		cpl3d_mul u_mul (.clk(clk), .en(en), .a(m2_a[i]), .b(m2_b[i]), .p(m2_p[i]));
	end

	for (genvar i = 0; i < 6; i++) begin : g_div
		cpl3d_div u_div (
			.clk (clk),
			.en  (en),
			.n   (m2_p[i][WN-1:0]),
			.d   (WW'(den_s[S_M2])),
			.q   (dq[i])
		);
	end

	always_comb begin
		// Parallel when the squared cosine, scaled exactly, exceeds (1 - t)^2.
		lhs   = PW'(ba2_s[S_M2]) << (2 * FB);
		par_c = par_all_q || (lhs > m2_p[6]);
		nos_c = (den_s[S_M2] == '0) || (den_s[S_M2] < thr_q);

		for (int k = 0; k < 6; k++) begin
			if (k < 3) begin
				sat_sum[k] = SW'(fs_s[S_DV][k]) + SW'(dq[k]);
			end else begin
				sat_sum[k] = SW'(ss_s[S_DV][k - 3]) + SW'(dq[k]);
			end
			if ((&sat_sum[k][SW-1:CW-1]) || !(|sat_sum[k][SW-1:CW-1])) begin
				sat_val[k] = sat_sum[k][CW-1:0];
			end else if (sat_sum[k][SW-1]) begin
				sat_val[k] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				sat_val[k] = {1'b0, {(CW-1){1'b1}}};
			end
		end

		sq_sum  = DOTW'(sq_s54[0]) + DOTW'(sq_s54[1]) + DOTW'(sq_s54[2]);
		short_c = !cfg.length_check_off && (sq_sum < DOTW'(lim_q));

		if (par_s[S_OUT-1]) begin
			stat_c = cpl3d_pkg::ST_PARALLEL;
		end else if (nos_s[S_OUT-1]) begin
			stat_c = cpl3d_pkg::ST_NO_SOLUTION;
		end else if (short_c) begin
			stat_c = cpl3d_pkg::ST_TOO_SHORT;
		end else begin
			stat_c = cpl3d_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pin_s1[0]  <= first_start_x;
			pin_s1[1]  <= first_start_y;
			pin_s1[2]  <= first_start_z;
			pin_s1[3]  <= first_end_x;
			pin_s1[4]  <= first_end_y;
			pin_s1[5]  <= first_end_z;
			pin_s1[6]  <= second_start_x;
			pin_s1[7]  <= second_start_y;
			pin_s1[8]  <= second_start_z;
			pin_s1[9]  <= second_end_x;
			pin_s1[10] <= second_end_y;
			pin_s1[11] <= second_end_z;

			// Direction vectors a and b and the offset c between start points.
			for (int k = 0; k < 3; k++) begin
				ad_s[2][k] <= DW'(pin_s1[3 + k]) - DW'(pin_s1[k]);
				bd_s[2][k] <= DW'(pin_s1[9 + k]) - DW'(pin_s1[6 + k]);
				c_s2[k]    <= DW'(pin_s1[k]) - DW'(pin_s1[6 + k]);
				fs_s[2][k] <= pin_s1[k];
				ss_s[2][k] <= pin_s1[6 + k];
			end
			for (int s = 3; s <= S_COMB; s++) begin
				ad_s[s] <= ad_s[s - 1];
				bd_s[s] <= bd_s[s - 1];
			end
			for (int s = 3; s <= S_DV; s++) begin
				fs_s[s] <= fs_s[s - 1];
				ss_s[s] <= ss_s[s - 1];
			end

			for (int k = 0; k < 3; k++) begin
				pr_s3[3*DI_CB + k] <= c_s2[k] * bd_s[2][k];
				pr_s3[3*DI_BA + k] <= bd_s[2][k] * ad_s[2][k];
				pr_s3[3*DI_CA + k] <= c_s2[k] * ad_s[2][k];
				pr_s3[3*DI_BB + k] <= bd_s[2][k] * bd_s[2][k];
				pr_s3[3*DI_AA + k] <= ad_s[2][k] * ad_s[2][k];
			end
			for (int d = 0; d < 5; d++) begin
				dot_s4[d] <= DOTW'(pr_s3[3*d]) + DOTW'(pr_s3[3*d + 1]) + DOTW'(pr_s3[3*d + 2]);
			end

			full_s10      <= m1_p[0][WW-1:0];
			ba2_s[S_COMB] <= m1_p[1][WW-1:0];
			den_s[S_COMB] <= m1_p[0][WW-1:0] - m1_p[1][WW-1:0];
			numa_s10      <= m1_p[2][WW-1:0] - m1_p[3][WW-1:0];
			numb_s10      <= m1_p[4][WW-1:0] - m1_p[5][WW-1:0];
			for (int s = S_COMB + 1; s <= S_M2; s++) begin
				ba2_s[s] <= ba2_s[s - 1];
				den_s[s] <= den_s[s - 1];
			end

			par_s[S_M2+1] <= par_c;
			nos_s[S_M2+1] <= nos_c;
			for (int s = S_M2 + 2; s <= S_OUT - 1; s++) begin
				par_s[s] <= par_s[s - 1];
				nos_s[s] <= nos_s[s - 1];
			end

			res_s[S_SAT] <= sat_val;
			for (int s = S_SAT + 1; s <= S_OUT - 1; s++) begin
				res_s[s] <= res_s[s - 1];
			end
			for (int k = 0; k < 3; k++) begin
				dif_s53[k] <= DW'(res_s[S_SAT][3 + k]) - DW'(res_s[S_SAT][k]);
				sq_s54[k]  <= dif_s53[k] * dif_s53[k];
			end

			stat_s55 <= stat_c;
			for (int k = 0; k < 6; k++) begin
				pt_s55[k] <= (stat_c == cpl3d_pkg::ST_OK) ? res_s[S_OUT-1][k] : '0;
			end
		end
	end

	assign status        = stat_s55;
	assign near_first_x  = pt_s55[0];
	assign near_first_y  = pt_s55[1];
	assign near_first_z  = pt_s55[2];
	assign near_second_x = pt_s55[3];
	assign near_second_y = pt_s55[4];
	assign near_second_z = pt_s55[5];

endmodule

// ===== verif/cpl3d_checker.sv =====
// Checker for the closest-points block: predicts each result word and compares it.
module cpl3d_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cpl3d_pkg::PAW-1:0]       paddr,
	input  logic [31:0]                     pwdata,
	input  logic                            pready,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [11:0][cpl3d_pkg::CW-1:0]  in_word,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [1:0]                      status,
	input  logic [5:0][cpl3d_pkg::CW-1:0]   out_pts,
	output int                              errors,
	output int                              pending
);
	localparam int CW  = cpl3d_pkg::CW;
	localparam int FB  = cpl3d_pkg::FB;
	localparam int PAW = cpl3d_pkg::PAW;
	localparam int ZTW = cpl3d_pkg::ZTW;
	localparam int MLW = cpl3d_pkg::MLW;

	typedef logic signed [319:0] wide_t;

	typedef struct {
		cpl3d_pkg::status_t st;
		logic [5:0][CW-1:0] pts;
	} nearest_t;

	nearest_t nearest_q[$];
	cpl3d_pkg::cfg_t cfg;
	int mismatches;

	function automatic wide_t div_round(input wide_t n, input wide_t d);
		wide_t m, q, r;
		m = (n < 0) ? -n : n;
		q = m / d;
		r = m % d;
		if ((r <<< 1) >= d)
			q = q + 1;
		return (n < 0) ? -q : q;
	endfunction

	function automatic wide_t clamp_coord(input wide_t s);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (CW - 1)) - 1;
		lo = -(wide_t'(1) <<< (CW - 1));
		if (s > hi)
			return hi;
		if (s < lo)
			return lo;
		return s;
	endfunction

	function automatic nearest_t closest_points(input logic [11:0][CW-1:0] w,
		input cpl3d_pkg::cfg_t c);
		nearest_t res;
		wide_t p[12];
		wide_t a[3], b[3], d[3], r[6];
		wide_t dcb, dba, dca, dbb, daa, full, den, numa, numb, g, lhs, rhs, zt, sum, lim, gap;
		logic par;
		for (int i = 0; i < 12; i++)
			p[i] = wide_t'($signed(w[i]));
		for (int k = 0; k < 3; k++) begin
			a[k] = p[3+k] - p[k];
			b[k] = p[9+k] - p[6+k];
			d[k] = p[k] - p[6+k];
		end
		dcb = d[0]*b[0] + d[1]*b[1] + d[2]*b[2];
		dba = b[0]*a[0] + b[1]*a[1] + b[2]*a[2];
		dca = d[0]*a[0] + d[1]*a[1] + d[2]*a[2];
		dbb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
		daa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
		full = daa * dbb;
		den = full - dba * dba;
		zt = wide_t'(c.zero_threshold);
		res.pts = '0;
		if (zt > (wide_t'(1) <<< FB)) begin
			par = 1'b1;
		end else begin
			g = (wide_t'(1) <<< FB) - zt;
			lhs = (dba * dba) <<< (2 * FB);
			rhs = g * g * full;
			par = lhs > rhs;
		end
		if (par) begin
			res.st = cpl3d_pkg::ST_PARALLEL;
			return res;
		end
		if (den == 0 || den < (zt <<< (3 * FB))) begin
			res.st = cpl3d_pkg::ST_NO_SOLUTION;
			return res;
		end
		numa = dcb * dba - dca * dbb;
		numb = dcb * daa - dca * dba;
		for (int k = 0; k < 3; k++) begin
			r[k] = clamp_coord(p[k] + div_round(numa * a[k], den));
			r[3+k] = clamp_coord(p[6+k] + div_round(numb * b[k], den));
		end
		if (!c.length_check_off) begin
			sum = 0;
			for (int k = 0; k < 3; k++) begin
				gap = r[3+k] - r[k];
				sum = sum + gap * gap;
			end
			lim = wide_t'(c.min_result_length) * wide_t'(c.min_result_length);
			if (sum < lim) begin
				res.st = cpl3d_pkg::ST_TOO_SHORT;
				return res;
			end
		end
		res.st = cpl3d_pkg::ST_OK;
		for (int k = 0; k < 6; k++)
			res.pts[k] = r[k][CW-1:0];
		return res;
	endfunction

	assign pending = nearest_q.size();

	always @(posedge clk or negedge arst_n) begin
		nearest_t exp_w;
		logic bad;
		if (!arst_n) begin
			cfg.zero_threshold = 1;
			cfg.min_result_length = 1;
			cfg.length_check_off = 1'b0;
			errors = 0;
			mismatches = 0;
			nearest_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PAW-1:2])
					cpl3d_pkg::REG_ZERO_THRESHOLD:    cfg.zero_threshold = pwdata[ZTW-1:0];
					cpl3d_pkg::REG_MIN_RESULT_LENGTH: cfg.min_result_length = pwdata[MLW-1:0];
					cpl3d_pkg::REG_LENGTH_CHECK_OFF:  cfg.length_check_off = pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				nearest_q.push_back(closest_points(in_word, cfg));
			if (out_valid && out_ready) begin
				if (nearest_q.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: status %0d", status);
				end else begin
					exp_w = nearest_q.pop_front();
					bad = (status !== exp_w.st);
					for (int k = 0; k < 6; k++)
						if (out_pts[k] !== exp_w.pts[k])
							bad = 1'b1;
					if (bad) begin
						errors++;
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: status exp %0d got %0d", exp_w.st, status);
							for (int k = 0; k < 6; k++)
								if (out_pts[k] !== exp_w.pts[k])
									$display("  point field %0d exp %h got %h", k,
										exp_w.pts[k], out_pts[k]);
						end
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb_closest_points_two_lines_3d_top.sv =====
// Testbench top for the closest-points block: stimulus, register setup and verdict.
module tb_closest_points_two_lines_3d_top;
	localparam int CW  = cpl3d_pkg::CW;
	localparam int PAW = cpl3d_pkg::PAW;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 70;
	localparam int RANDOM_PER_PHASE = 255;
	localparam int LONG_HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PAW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [11:0][CW-1:0] seg_word;
	logic [5:0][CW-1:0] near_word;
	logic [1:0] status;
	int errors, pending;
	int idle_cycles;
	int hold_requests;

	closest_points_two_lines_3d_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_start_x(seg_word[0]), .first_start_y(seg_word[1]),
		.first_start_z(seg_word[2]), .first_end_x(seg_word[3]),
		.first_end_y(seg_word[4]), .first_end_z(seg_word[5]),
		.second_start_x(seg_word[6]), .second_start_y(seg_word[7]),
		.second_start_z(seg_word[8]), .second_end_x(seg_word[9]),
		.second_end_y(seg_word[10]), .second_end_z(seg_word[11]),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.near_first_x(near_word[0]), .near_first_y(near_word[1]),
		.near_first_z(near_word[2]), .near_second_x(near_word[3]),
		.near_second_y(near_word[4]), .near_second_z(near_word[5])
	);

	// The checker sits beside the block and sees exactly what crosses its ports.
	cpl3d_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(seg_word),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.out_pts(near_word), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The watchdog ends the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[closest_points_two_lines_3d_top] ERROR");
				$finish;
			end
		end
	end

	// The receiver runs its own pattern of ready stretches, random stalls and
	// solid stalls. A long hold, requested by the stimulus, keeps it off so
	// that the pipeline fills and drops in_ready.
	initial begin
		int run_len;
		int run_kind;
		int holds_served;
		out_ready = 1'b0;
		holds_served = 0;
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
			end
			run_len = $urandom_range(1, 40);
			run_kind = $urandom_range(0, 3);
			for (int i = 0; i < run_len; i++) begin
				@(negedge clk);
				if (run_kind == 0) begin
					out_ready <= 1'b0;
				end else if (run_kind == 1) begin
					out_ready <= $urandom_range(0, 1);
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// One register write: a setup phase, then an access phase in which the
	// register takes the value at the rising edge.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PAW'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Wait until every expected word has come back, then a drain period longer than the pipeline depth.
	task automatic drain_results();
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offer one segment pair and hold it until the block takes it. in_valid
	// stays high afterwards; the caller lowers it only when a gap follows.
	task automatic offer_segments(input logic [11:0][CW-1:0] w);
		seg_word <= w;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic [CW-1:0] small_coord(input int span);
		return CW'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic logic [CW-1:0] edge_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// Random segment pairs. Most are well-formed geometry at moderate scale
	// (skew, intersecting, parallel, degenerate); the rest are full-range
	// noise and values at the extremes that drive the outputs into saturation.
	function automatic logic [11:0][CW-1:0] random_segments();
		logic [11:0][CW-1:0] w;
		logic [2:0][CW-1:0] dir_a, dir_b, pivot;
		int sel, span, scale;
		sel = $urandom_range(0, 99);
		span = 1 << $urandom_range(4, 22);
		for (int i = 0; i < 12; i++)
			w[i] = small_coord(span);
		for (int k = 0; k < 3; k++) begin
			dir_a[k] = small_coord(span);
			dir_b[k] = small_coord(span);
			pivot[k] = small_coord(span);
		end
		if (sel < 25) begin
			for (int i = 0; i < 12; i++)
				w[i] = $urandom;
		end else if (sel < 38) begin
			for (int i = 0; i < 12; i++)
				w[i] = edge_coord();
		end else if (sel < 55) begin
			// Lines crossing at a common point: the result segment is nearly empty.
			for (int k = 0; k < 3; k++) begin
				w[k] = pivot[k] - dir_a[k];
				w[3+k] = pivot[k] + dir_a[k];
				w[6+k] = pivot[k] - dir_b[k];
				w[9+k] = pivot[k] + dir_b[k];
			end
		end else if (sel < 67) begin
			// Parallel or nearly parallel directions.
			scale = $urandom_range(1, 3);
			for (int k = 0; k < 3; k++) begin
				w[3+k] = w[k] + dir_a[k];
				w[9+k] = w[6+k] + ((sel % 2) ? -scale : scale) * $signed(dir_a[k])
					+ $urandom_range(0, 2) - 1;
			end
		end else if (sel < 73) begin
			// One segment or both collapse to a single point.
			for (int k = 0; k < 3; k++) begin
				if (sel != 72)
					w[3+k] = w[k];
				if (sel >= 70)
					w[9+k] = w[6+k];
			end
		end
		return w;
	endfunction

	task automatic random_burst_run(input int count, input bit pause_midway);
		int sent, burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && sent < count; i++) begin
				offer_segments(random_segments());
				sent++;
			end
			if (pause_midway && sent >= count / 2 && sent - burst < count / 2) begin
				// Sender stops until every expected word has arrived.
				in_valid <= 1'b0;
				while (pending != 0)
					@(posedge clk);
				@(negedge clk);
			end
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	task automatic set_registers(input logic [15:0] zt, input logic [30:0] ml, input bit off);
		reg_write(cpl3d_pkg::REG_ZERO_THRESHOLD, {16'h0, zt});
		reg_write(cpl3d_pkg::REG_MIN_RESULT_LENGTH, {1'b0, ml});
		reg_write(cpl3d_pkg::REG_LENGTH_CHECK_OFF, {31'h0, off});
	endtask

	initial begin
		logic [11:0][CW-1:0] w;
		logic [11:0][CW-1:0] directed[$];
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		seg_word = '0;
		hold_requests = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words under the reset register values.
		directed.push_back('0);
		directed.push_back({12{32'h7fff_ffff}});
		directed.push_back({12{32'h8000_0000}});
		for (int i = 0; i < 12; i++)
			w[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
		directed.push_back(w);
		for (int i = 0; i < 12; i++)
			w[i] = (i % 2) ? 32'h7fff_ffff : 32'h8000_0000;
		directed.push_back(w);
		// Skew lines: x axis at z = 0 against y axis at z = 1.
		w = '0;
		w[3] = 32'h0001_0000;
		w[8] = 32'h0001_0000;
		w[10] = 32'h0001_0000;
		w[11] = 32'h0001_0000;
		directed.push_back(w);
		// Same pair moved far apart so that a point lands on the edge of the coordinate range.
		w[0] = 32'h7fff_0000;
		w[3] = 32'h7fff_8000;
		w[6] = 32'h8000_0000;
		w[9] = 32'h8000_0000;
		directed.push_back(w);
		// Exactly parallel, antiparallel, and crossing at the origin.
		w = '0;
		w[3] = 32'h0002_0000;
		w[7] = 32'h0001_0000;
		w[9] = 32'h0003_0000;
		w[10] = 32'h0001_0000;
		directed.push_back(w);
		w[9] = 32'hfffd_0000;
		directed.push_back(w);
		w = '0;
		w[0] = 32'hffff_0000;
		w[3] = 32'h0001_0000;
		w[7] = 32'hffff_0000;
		w[10] = 32'h0001_0000;
		directed.push_back(w);
		// Degenerate segments: one, then both reduced to a point.
		w = '0;
		w[0] = 32'h0000_5000;
		w[3] = 32'h0000_5000;
		w[9] = 32'h0001_0000;
		directed.push_back(w);
		w[9] = 32'h0;
		directed.push_back(w);
		foreach (directed[i])
			offer_segments(directed[i]);
		in_valid <= 1'b0;
		random_burst_run(RANDOM_PER_PHASE, 1'b0);
		drain_results();

		// Zero tolerance and no length limit.
		set_registers(16'd0, 31'd0, 1'b0);
		foreach (directed[i])
			offer_segments(directed[i]);
		// The receiver now holds off long enough for the pipeline to back up.
		hold_requests++;
		random_burst_run(RANDOM_PER_PHASE, 1'b0);
		drain_results();

		// Largest tolerance and longest length limit.
		set_registers(16'hffff, 31'h7fff_ffff, 1'b0);
		random_burst_run(RANDOM_PER_PHASE, 1'b1);
		drain_results();

		// Length check turned off.
		set_registers(16'd0, 31'd0, 1'b1);
		random_burst_run(RANDOM_PER_PHASE, 1'b0);
		drain_results();

		// Mid-range settings.
		set_registers(16'd300, 31'h0001_0000, 1'b0);
		random_burst_run(RANDOM_PER_PHASE, 1'b0);
		drain_results();

		set_registers(16'd1, 31'd1, 1'b1);
		random_burst_run(RANDOM_PER_PHASE, 1'b0);
		drain_results();

		if (errors == 0)
			$display("[closest_points_two_lines_3d_top] OK");
		else
			$display("[closest_points_two_lines_3d_top] ERROR");
		$finish;
	end

endmodule
